### sv/xsp_pkg.sv
// shared types, constants and helper functions of the xorshift64* generator
package xsp_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned BOUND_W = 32;
  localparam int unsigned PID_W   = 32;
  localparam int unsigned VALUE_W = 64;

  // command codes
  localparam logic [CMD_W-1:0] CMD_U64    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_U32    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BELOW  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESEED = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DERIVE = 3'd4;

  // mixing and output constants
  localparam logic [63:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] STAR_MUL   = 64'h2545_F491_4F6C_DD1D;
  localparam logic [63:0] ZERO_FILL  = 64'hA5A5_A5A5_A5A5_A5A5;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_THR,
    ST_MOD,
    ST_MIX1,
    ST_MIX2,
    ST_OUT
  } xsp_state_e;

  // request to the shared 64-bit multiplier
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  // request to the shared 32-bit remainder unit
  typedef struct packed {
    logic        start;
    logic [31:0] dvd;
    logic [31:0] dsr;
  } rem_req_t;

  // one xorshift step: right 12, left 25, right 27
  function automatic logic [63:0] xs_step(input logic [63:0] x);
    logic [63:0] y;
    y = x ^ (x >> 12);
    y = y ^ (y << 25);
    y = y ^ (y >> 27);
    return y;
  endfunction

  // splitmix64 front end: add golden increment, then xor-shift by 30
  function automatic logic [63:0] mix_pre(input logic [63:0] v);
    logic [63:0] z;
    z = v + GOLDEN_INC;
    return z ^ (z >> 30);
  endfunction

  // elaboration-time full splitmix64 with zero replacement, for the reset state
  function automatic logic [63:0] seed_const(input logic [63:0] v);
    logic [63:0] z;
    z = mix_pre(v) * MIX_MUL_A;
    z = (z ^ (z >> 27)) * MIX_MUL_B;
    z = z ^ (z >> 31);
    return (z == 64'd0) ? ZERO_FILL : z;
  endfunction

  localparam logic [63:0] GEN_RESET = seed_const(64'd0);

endpackage

### sv/xsp_req_if.sv
// request channel: command, bound and pid with valid/ready handshake
interface xsp_req_if import xsp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [BOUND_W-1:0] bound;
  logic [PID_W-1:0]   pid;

  modport source (output valid, output cmd, output bound, output pid, input ready);
  modport sink   (input valid, input cmd, input bound, input pid, output ready);
endinterface

### sv/xsp_rsp_if.sv
// response channel: 64-bit value with valid/ready handshake
interface xsp_rsp_if import xsp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

### sv/xsp_mul64.sv
// iterative 64x64 low-half multiplier built on one 32x32 multiplier
module xsp_mul64 import xsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mul_req_t    req_i,
  output logic        done_o,
  output logic [63:0] prod_o
);

  logic [63:0] a_q, b_q;
  logic [63:0] mres_q, acc_q;
  logic [1:0]  cnt_q;
  logic        busy_q, done_q;
  logic [31:0] opa, opb;
  logic [63:0] mul_w;

  // partial product select: lo*lo, lo*hi, hi*lo
  always_comb begin
    unique case (cnt_q)
      2'd0: begin
        opa = a_q[31:0];
        opb = b_q[31:0];
      end
      2'd1: begin
        opa = a_q[31:0];
        opb = b_q[63:32];
      end
      2'd2: begin
        opa = a_q[63:32];
        opb = b_q[31:0];
      end
      default: begin
        opa = 32'd0;
        opb = 32'd0;
      end
    endcase
  end

  assign mul_w = 64'(opa) * 64'(opb);

  // control: step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: registered partial product, then accumulate
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end else if (busy_q) begin
      mres_q <= mul_w;
      if (cnt_q == 2'd1) begin
        acc_q <= mres_q;
      end else if (cnt_q != 2'd0) begin
        acc_q <= acc_q + {mres_q[31:0], 32'd0};
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### sv/xsp_rem32.sv
// restoring 32-bit remainder unit, one quotient bit per cycle
module xsp_rem32 import xsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rem_req_t    req_i,
  output logic        done_o,
  output logic [31:0] rem_o
);

  logic [31:0] dvd_q, dsr_q, rem_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] trial;
  logic        ge;
  logic [31:0] rem_next;

  // trial subtract of the shifted partial remainder
  always_comb begin
    trial    = {rem_q, dvd_q[31]};
    ge       = (trial >= {1'b0, dsr_q});
    rem_next = ge ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
  end

  // control: bit counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: shift dividend out, keep partial remainder
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dvd;
      dsr_q <= req_i.dsr;
      rem_q <= 32'd0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      rem_q <= rem_next;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### sv/xorshift64_star_prng_unit.sv
// xorshift64* generator top level: sequencer, state registers and output stage
//
// Requests arrive on req (cmd, bound, pid) and each one gives exactly one
// response on rsp (value). The 64-bit seed register is written through
// seed_we_i/seed_wdata_i; the user must write it only while the block is
// idle, which the block itself does not enforce. Writing it does not reseed.
// One request is worked on at a time; req.ready is high only when the
// sequencer is idle. Every 64-bit product goes through one shared 32x32
// multiplier, and every modulo through one shared restoring remainder unit.
// A 64- or 32-bit draw takes one product, reseed and derivation take two,
// and a uniform draw below a nonzero bound takes a threshold modulo, one
// product per draw and a final modulo; a zero bound or unused command uses
// neither unit. The next request is taken the cycle after the response
// register loads. The response sits in an output register, so a new request
// is taken while the receiver stalls; a finished result then waits in the
// sequencer until the output register frees up. Reset loads the generator
// state with the mixed value of a zero seed and clears the seed register.
module xorshift64_star_prng_unit import xsp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              seed_we_i,
  input  logic [63:0]       seed_wdata_i,
  xsp_req_if.sink           req,
  xsp_rsp_if.source         rsp
);

  xsp_state_e   state_q, state_d;
  logic [CMD_W-1:0] cmd_q;
  logic [31:0]  bound_q;
  logic [31:0]  th_q;
  logic [63:0]  gen_q, seed_q;
  logic [63:0]  res_q;
  logic         out_valid_q;
  logic [63:0]  out_value_q;

  mul_req_t     mul_req;
  rem_req_t     rem_req;
  logic         mul_done, rem_done;
  logic [63:0]  mul_prod;
  logic [31:0]  rem_val;

  logic         accept;
  logic         gen_ld, th_ld, res_ld, out_ld;
  logic [63:0]  gen_d, res_d;
  logic [63:0]  xs_next, mix_mid, mix_fin;
  logic [31:0]  draw;

  xsp_mul64 u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  xsp_rem32 u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .done_o (rem_done),
    .rem_o  (rem_val)
  );

  // handshake and shared datapath terms
  assign req.ready = (state_q == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign xs_next   = xs_step(gen_q);
  assign draw      = mul_prod[63:32];
  assign mix_mid   = mul_prod ^ (mul_prod >> 27);
  assign mix_fin   = mul_prod ^ (mul_prod >> 31);
  assign out_ld    = (state_q == ST_OUT) && (!out_valid_q || rsp.ready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req.cmd)
            CMD_U64, CMD_U32: state_d = ST_STEP;
            CMD_BELOW:        state_d = (req.bound == 32'd0) ? ST_OUT : ST_THR;
            CMD_RESEED, CMD_DERIVE: state_d = ST_MIX1;
            default:          state_d = ST_OUT;
          endcase
        end
      end
      ST_STEP: begin
        if (mul_done) begin
          if (cmd_q != CMD_BELOW) begin
            state_d = ST_OUT;
          end else if (draw >= th_q) begin
            state_d = ST_MOD;
          end
        end
      end
      ST_THR:  if (rem_done) state_d = ST_STEP;
      ST_MOD:  if (rem_done) state_d = ST_OUT;
      ST_MIX1: if (mul_done) state_d = ST_MIX2;
      ST_MIX2: if (mul_done) state_d = ST_OUT;
      ST_OUT:  if (out_ld) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // unit requests and register loads
  always_comb begin
    mul_req = '0;
    rem_req = '0;
    gen_ld  = 1'b0;
    gen_d   = xs_next;
    th_ld   = 1'b0;
    res_ld  = 1'b0;
    res_d   = 64'd0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req.cmd)
            CMD_U64, CMD_U32: begin
              mul_req = '{start: 1'b1, a: xs_next, b: STAR_MUL};
              gen_ld  = 1'b1;
            end
            CMD_BELOW: begin
              if (req.bound == 32'd0) begin
                res_ld = 1'b1;
              end else begin
                rem_req = '{start: 1'b1, dvd: 32'd0 - req.bound, dsr: req.bound};
              end
            end
            CMD_RESEED: mul_req = '{start: 1'b1, a: mix_pre(seed_q), b: MIX_MUL_A};
            CMD_DERIVE: begin
              mul_req = '{start: 1'b1, a: mix_pre(seed_q ^ {req.pid, req.pid}),
                          b: MIX_MUL_A};
            end
            default: res_ld = 1'b1;
          endcase
        end
      end
      ST_STEP: begin
        if (mul_done) begin
          if (cmd_q == CMD_U64) begin
            res_ld = 1'b1;
            res_d  = mul_prod;
          end else if (cmd_q == CMD_U32) begin
            res_ld = 1'b1;
            res_d  = {32'd0, draw};
          end else if (draw >= th_q) begin
            rem_req = '{start: 1'b1, dvd: draw, dsr: bound_q};
          end else begin
            // rejected draw: step again
            mul_req = '{start: 1'b1, a: xs_next, b: STAR_MUL};
            gen_ld  = 1'b1;
          end
        end
      end
      ST_THR: begin
        if (rem_done) begin
          th_ld   = 1'b1;
          mul_req = '{start: 1'b1, a: xs_next, b: STAR_MUL};
          gen_ld  = 1'b1;
        end
      end
      ST_MOD: begin
        if (rem_done) begin
          res_ld = 1'b1;
          res_d  = {32'd0, rem_val};
        end
      end
      ST_MIX1: begin
        if (mul_done) mul_req = '{start: 1'b1, a: mix_mid, b: MIX_MUL_B};
      end
      ST_MIX2: begin
        if (mul_done) begin
          res_ld = 1'b1;
          if (cmd_q == CMD_RESEED) begin
            gen_ld = 1'b1;
            gen_d  = (mix_fin == 64'd0) ? ZERO_FILL : mix_fin;
          end else begin
            res_d = mix_fin;
          end
        end
      end
      default: ;
    endcase
  end

  // control state, generator state and seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gen_q       <= GEN_RESET;
      seed_q      <= 64'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (gen_ld) gen_q <= gen_d;
      if (seed_we_i) seed_q <= seed_wdata_i;
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // transaction payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= req.cmd;
      bound_q <= req.bound;
    end
    if (th_ld) th_q <= rem_val;
    if (res_ld) res_q <= res_d;
    if (out_ld) out_value_q <= res_q;
  end

  assign rsp.valid = out_valid_q;
  assign rsp.value = out_value_q;

`ifndef SYNTHESIS
  // the generator state never reaches zero
  a_gen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_q != 64'd0)
    else $error("generator state is zero");

  // the remainder unit only runs with a nonzero divisor
  a_rem_dsr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_THR || state_q == ST_MOD) |-> bound_q != 32'd0)
    else $error("remainder with zero bound");

  // remainder results only arrive while the sequencer waits for them
  a_rem_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> (state_q == ST_THR || state_q == ST_MOD))
    else $error("unexpected remainder completion");

  // a result enters the output register only when it is free or draining
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ld |-> (!out_valid_q || rsp.ready))
    else $error("output register overwritten");
`endif

endmodule

### dv/tb_xorshift64_star_prng_unit.sv
// testbench for the xorshift64* generator: predicts every response from the request stream
module tb_xorshift64_star_prng_unit;
  import xsp_pkg::*;

  // seed whose splitmix64 image is zero, so reseed falls back to the fill pattern
  localparam logic [63:0] SEED_MIX_ZERO = 64'h61C8_8646_80B5_83EB;
  // command codes that the block answers with zero
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_DERIVE + 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = '1;
  localparam int unsigned MAX_GAP     = 13;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned NUM_PHASES  = 7;

  // generator model and queue of predicted response values
  class prng_scoreboard;
    logic [63:0] gen_state;
    logic [63:0] seed_reg;
    logic [63:0] pending_values[$];
    int unsigned error_count;

    function new();
      seed_reg    = 64'd0;
      gen_state   = seeded_state(64'd0);
      error_count = 0;
    endfunction

    // splitmix64 finalizer
    function logic [63:0] mix64(input logic [63:0] v);
      logic [63:0] z;
      z = v + GOLDEN_INC;
      z = (z ^ (z >> 30)) * MIX_MUL_A;
      z = (z ^ (z >> 27)) * MIX_MUL_B;
      return z ^ (z >> 31);
    endfunction

    function logic [63:0] seeded_state(input logic [63:0] v);
      logic [63:0] s;
      s = mix64(v);
      return (s == 64'd0) ? ZERO_FILL : s;
    endfunction

    // advance the state by one xorshift step and return the scrambled output
    function logic [63:0] next_u64();
      logic [63:0] x;
      x = gen_state;
      x = x ^ (x >> 12);
      x = x ^ (x << 25);
      x = x ^ (x >> 27);
      gen_state = x;
      return x * STAR_MUL;
    endfunction

    // rejection sampling below bound on the upper output half
    function logic [31:0] draw_below(input logic [31:0] bound);
      logic [31:0] threshold;
      logic [63:0] full;
      logic [31:0] r;
      if (bound == 32'd0) return 32'd0;
      threshold = (32'd0 - bound) % bound;
      forever begin
        full = next_u64();
        r    = full[63:32];
        if (r >= threshold) return r % bound;
      end
    endfunction

    function void set_seed(input logic [63:0] v);
      seed_reg = v;
    endfunction

    function int unsigned pending();
      return pending_values.size();
    endfunction

    // accepted request transaction: predict its response
    function void note_request(input logic [CMD_W-1:0] cmd, input logic [31:0] bound,
                               input logic [31:0] pid);
      logic [63:0] v;
      logic [63:0] full;
      v = 64'd0;
      case (cmd)
        CMD_U64: v = next_u64();
        CMD_U32: begin
          full = next_u64();
          v    = {32'd0, full[63:32]};
        end
        CMD_BELOW:  v = {32'd0, draw_below(bound)};
        CMD_RESEED: gen_state = seeded_state(seed_reg);
        CMD_DERIVE: v = mix64(seed_reg ^ {pid, pid});
        default:    v = 64'd0;
      endcase
      pending_values.push_back(v);
    endfunction

    // accepted response transaction: compare with the oldest prediction
    function void check_response(input logic [63:0] value);
      logic [63:0] exp_value;
      if (pending_values.size() == 0) begin
        $error("value: response with none expected, actual %h", value);
        error_count++;
        return;
      end
      exp_value = pending_values.pop_front();
      if (value !== exp_value) begin
        $error("value mismatch: expected %h, actual %h", exp_value, value);
        error_count++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        seed_we_i;
  logic [63:0] seed_wdata_i;
  logic        steady_flow;

  xsp_req_if req_if ();
  xsp_rsp_if rsp_if ();

  prng_scoreboard sb;

  xorshift64_star_prng_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_we_i   (seed_we_i),
    .seed_wdata_i(seed_wdata_i),
    .req         (req_if),
    .rsp         (rsp_if)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // observe both channels at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) sb.note_request(req_if.cmd, req_if.bound, req_if.pid);
      if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.value);
    end
  end

  // run limit
  initial begin
    #50_000_000;
    $display("xorshift64_star_prng_unit: mismatch");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return steady_flow ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // present one request transaction and hold it until accepted
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [31:0] bound,
                              input logic [31:0] pid);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.cmd   <= cmd;
    req_if.bound <= bound;
    req_if.pid   <= pid;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // stop sending and wait until every predicted response has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [63:0] v);
    seed_we_i    <= 1'b1;
    seed_wdata_i <= v;
    @(posedge clk_i);
    seed_we_i <= 1'b0;
    sb.set_seed(v);
  endtask

  task automatic random_request();
    logic [CMD_W-1:0] cmd;
    logic [31:0]      bound;
    if ($urandom_range(0, 99) < 8) begin
      cmd = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    end else begin
      cmd = CMD_W'($urandom_range(CMD_U64, CMD_DERIVE));
    end
    // bounds cluster where the rejection threshold is interesting
    case ($urandom_range(0, 4))
      0:       bound = $urandom_range(0, 16);
      1:       bound = $urandom;
      2:       bound = 32'h8000_0000 + $urandom_range(0, 16);
      3:       bound = 32'hFFFF_FFFF - $urandom_range(0, 16);
      default: bound = 32'd1 << $urandom_range(0, 31);
    endcase
    send_request(cmd, bound, $urandom);
  endtask

  // receiver: random stall before each response transaction
  initial begin
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  // stimulus
  initial begin
    logic [63:0] phase_seed;
    sb = new();
    steady_flow  = 1'b0;
    rst_ni       <= 1'b0;
    seed_we_i    <= 1'b0;
    seed_wdata_i <= 64'd0;
    req_if.valid <= 1'b0;
    req_if.cmd   <= CMD_U64;
    req_if.bound <= 32'd0;
    req_if.pid   <= 32'd0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset state, every command, bound extremes
    send_request(CMD_U64, 32'd0, 32'd0);
    send_request(CMD_U32, 32'd0, 32'd0);
    send_request(CMD_BELOW, 32'd0, 32'd0);
    send_request(CMD_BELOW, 32'd1, 32'd0);
    send_request(CMD_BELOW, 32'd2, 32'd0);
    send_request(CMD_BELOW, 32'd3, 32'd0);
    send_request(CMD_BELOW, 32'h8000_0000, 32'd0);
    send_request(CMD_BELOW, 32'h8000_0001, 32'd0);
    send_request(CMD_BELOW, 32'hFFFF_FFFE, 32'd0);
    send_request(CMD_BELOW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_DERIVE, 32'd0, 32'd0);
    send_request(CMD_DERIVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_RESEED, 32'd0, 32'd0);
    send_request(CMD_U64, 32'd0, 32'd0);
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
      send_request(CMD_W'(c), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
    // seed whose mixed value is zero: reseed takes the fill pattern
    write_seed(SEED_MIX_ZERO);
    send_request(CMD_DERIVE, 32'd0, 32'd0);
    send_request(CMD_RESEED, 32'd0, 32'd0);
    send_request(CMD_U64, 32'd0, 32'd0);
    send_request(CMD_U32, 32'd0, 32'd0);
    drain();
    write_seed('1);
    send_request(CMD_DERIVE, 32'd0, 32'h5A5A_A5A5);
    send_request(CMD_RESEED, 32'd0, 32'd0);
    send_request(CMD_U64, 32'd0, 32'd0);

    // random phases, each under its own seed
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        0:       phase_seed = 64'd0;
        1:       phase_seed = 64'd1;
        2:       phase_seed = 64'h8000_0000_0000_0000;
        3:       phase_seed = SEED_MIX_ZERO;
        default: phase_seed = {$urandom, $urandom};
      endcase
      write_seed(phase_seed);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
        // hold off until the pipeline is empty
        if (i == PHASE_ITEMS / 2) drain();
        random_request();
      end
    end

    drain();
    repeat (60) @(posedge clk_i);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("xorshift64_star_prng_unit: match");
    end else begin
      $display("xorshift64_star_prng_unit: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
sv/xsp_pkg.sv
sv/xsp_req_if.sv
sv/xsp_rsp_if.sv
sv/xsp_mul64.sv
sv/xsp_rem32.sv
sv/xorshift64_star_prng_unit.sv
dv/tb_xorshift64_star_prng_unit.sv
